// ===== src/lagged_fibonacci_uniform_generator_defines.svh =====
`ifndef LAGGED_FIBONACCI_UNIFORM_GENERATOR_DEFINES_SVH
`define LAGGED_FIBONACCI_UNIFORM_GENERATOR_DEFINES_SVH

// same-cycle implication
`define LFUG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LFUG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lfug_pkg.sv =====
package lfug_pkg;

  localparam int TBL_LEN   = 97;
  localparam int TAP_SHORT = 64;
  localparam int ENTRY_W   = 25;
  localparam int FRAC_W    = 24;
  localparam int MAX_W     = 31;
  localparam int SEED_W    = 32;
  localparam int GRP_ORD   = 178;
  localparam int MOD_P     = 179;
  localparam int L_MOD     = 169;

  localparam logic REQ_RESEED = 1'b0;
  localparam logic REQ_DRAW   = 1'b1;

  localparam logic [ENTRY_W-1:0] ONE_UNIT   = 25'h100_0000;
  localparam logic [FRAC_W-1:0]  CARRY_INIT = 24'd362436;
  localparam logic [ENTRY_W-1:0] CARRY_STEP = 25'd7654321;
  localparam logic [FRAC_W-1:0]  CARRY_MOD  = 24'd16777213;

  localparam logic [15:0] SEED_A_MAX = 16'd31328;
  localparam logic [15:0] SEED_B_MAX = 16'd30081;
  localparam logic [15:0] DEF_A      = 16'd1802;
  localparam logic [15:0] DEF_B      = 16'd9373;
  localparam logic [14:0] DIV_A      = 15'd177;
  localparam logic [14:0] DIV_B      = 15'd169;
  localparam logic [8:0]  ORD_L      = 9'd178;

  localparam logic [4:0] LAST_BIT  = 5'd23;
  localparam logic [6:0] LAST_WORD = 7'd96;

  typedef logic [ENTRY_W-1:0] entry_t;

  typedef struct packed {
    logic fwd;
    logic back;
  } ring_ctrl_t;

  typedef struct packed {
    logic push;
    logic last;
  } fill_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_DRAW,
    ST_MULT
  } top_state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DIV,
    PH_RUN
  } seed_phase_t;

  // powers of the primitive root 2 modulo 179
  function automatic logic [GRP_ORD-1:0][7:0] build_exp();
    logic [GRP_ORD-1:0][7:0] t;
    logic [8:0] v;
    t = '0;
    v = 9'd1;
    for (int e = 0; e < GRP_ORD; e++) begin
      t[e] = v[7:0];
      v = v << 1;
      if (v >= 9'(MOD_P)) begin
        v = v - 9'(MOD_P);
      end
    end
    return t;
  endfunction

  localparam logic [GRP_ORD-1:0][7:0] EXP_TBL = build_exp();

  function automatic logic [MOD_P-1:0][7:0] build_log();
    logic [MOD_P-1:0][7:0] t;
    t = '0;
    for (int e = 0; e < GRP_ORD; e++) begin
      t[EXP_TBL[e]] = 8'(e);
    end
    return t;
  endfunction

  localparam logic [MOD_P-1:0][7:0] LOG_TBL = build_log();

  // (53*l + 1) mod 169
  function automatic logic [L_MOD-1:0][7:0] build_nextl();
    logic [L_MOD-1:0][7:0] t;
    logic [8:0] v;
    t = '0;
    v = 9'd1;
    for (int l = 0; l < L_MOD; l++) begin
      t[l] = v[7:0];
      v = v + 9'd53;
      if (v >= 9'(L_MOD)) begin
        v = v - 9'(L_MOD);
      end
    end
    return t;
  endfunction

  localparam logic [L_MOD-1:0][7:0] NEXTL_TBL = build_nextl();

endpackage

// ===== src/lfug_cell.sv =====
module lfug_cell import lfug_pkg::*; (
  input  logic       clk,
  input  ring_ctrl_t ctrl,
  input  entry_t     left,
  input  entry_t     right,
  output entry_t     q
);

  always_ff @(posedge clk) begin
    if (ctrl.fwd) begin
      q <= right;
    end else if (ctrl.back) begin
      q <= left;
    end
  end

endmodule

// ===== src/lfug_ring.sv =====
module lfug_ring import lfug_pkg::*; (
  input  logic       clk,
  input  ring_ctrl_t ctrl,
  input  entry_t     fill_word,
  input  entry_t     head_word,
  output entry_t     tap_long,
  output entry_t     tap_short
);

  entry_t q [TBL_LEN];

  // cell c holds table entry (long index - c) mod 97
  for (genvar c = 0; c < TBL_LEN; c++) begin : g_cell
    entry_t left;
    entry_t right;

    if (c == 0) begin : g_first
      assign left = fill_word;
    end else begin : g_mid_l
      assign left = q[c-1];
    end

    if (c == TBL_LEN - 1) begin : g_last
      assign right = head_word;
    end else begin : g_mid_r
      assign right = q[c+1];
    end

    lfug_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .left  (left),
      .right (right),
      .q     (q[c])
    );
  end

  assign tap_long  = q[0];
  assign tap_short = q[TAP_SHORT];

endmodule

// ===== src/lfug_seeder.sv =====
module lfug_seeder import lfug_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              use_default,
  input  logic [SEED_W-1:0] seed_word,
  output fill_t             fill,
  output logic [FRAC_W-1:0] word
);

  seed_phase_t phase, phase_next;

  logic [14:0] rem_a, rem_b;
  logic [7:0]  q_a, q_b;
  logic [7:0]  log_i, log_j, log_k, lv;
  logic [22:0] acc;
  logic [4:0]  bit_cnt;
  logic [6:0]  word_cnt;

  logic [15:0] half_a, half_b, sel_a, sel_b;
  logic        bad;
  logic        div_done;
  logic [8:0]  s1, s2;
  logic [7:0]  s1r, log_m;
  logic [7:0]  m_val, l_new;
  logic [11:0] prod;
  logic        new_bit;

  assign half_a = seed_word[15:0];
  assign half_b = seed_word[31:16];
  assign bad = use_default || half_a == '0 || half_a > SEED_A_MAX ||
               half_b == '0 || half_b > SEED_B_MAX;
  assign sel_a = bad ? DEF_A : half_a;
  assign sel_b = bad ? DEF_B : half_b;

  assign div_done = rem_a < DIV_A && rem_b < DIV_B;

  // product of i, j, k taken as a sum of logarithms mod 178
  assign s1    = {1'b0, log_i} + {1'b0, log_j};
  assign s1r   = (s1 >= ORD_L) ? 8'(s1 - ORD_L) : s1[7:0];
  assign s2    = {1'b0, s1r} + {1'b0, log_k};
  assign log_m = (s2 >= ORD_L) ? 8'(s2 - ORD_L) : s2[7:0];
  assign m_val = EXP_TBL[log_m];
  assign l_new = NEXTL_TBL[lv];
  assign prod  = l_new[5:0] * m_val[5:0];
  assign new_bit = prod[5];

  assign word      = {acc, new_bit};
  assign fill.push = phase == PH_RUN && bit_cnt == LAST_BIT;
  assign fill.last = fill.push && word_cnt == LAST_WORD;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (start) begin
          phase_next = PH_DIV;
        end
      end
      PH_DIV: begin
        if (div_done) begin
          phase_next = PH_RUN;
        end
      end
      PH_RUN: begin
        if (fill.last) begin
          phase_next = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt  <= '0;
      word_cnt <= '0;
      log_i    <= '0;
      log_j    <= '0;
      log_k    <= '0;
      lv       <= '0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            rem_a <= sel_a[14:0];
            rem_b <= sel_b[14:0];
            q_a   <= '0;
            q_b   <= '0;
          end
        end
        PH_DIV: begin
          if (rem_a >= DIV_A) begin
            rem_a <= rem_a - DIV_A;
            q_a   <= q_a + 8'd1;
          end
          if (rem_b >= DIV_B) begin
            rem_b <= rem_b - DIV_B;
            q_b   <= q_b + 8'd1;
          end
          if (div_done) begin
            log_i    <= LOG_TBL[q_a + 8'd2];
            log_j    <= LOG_TBL[rem_a[7:0] + 8'd2];
            log_k    <= LOG_TBL[q_b + 8'd1];
            lv       <= rem_b[7:0];
            bit_cnt  <= '0;
            word_cnt <= '0;
          end
        end
        PH_RUN: begin
          log_i <= log_j;
          log_j <= log_k;
          log_k <= log_m;
          lv    <= l_new;
          acc   <= {acc[21:0], new_bit};
          if (bit_cnt == LAST_BIT) begin
            bit_cnt  <= '0;
            word_cnt <= word_cnt + 7'd1;
          end else begin
            bit_cnt <= bit_cnt + 5'd1;
          end
        end
        default: begin
          bit_cnt <= '0;
        end
      endcase
    end
  end

endmodule

// ===== src/lagged_fibonacci_uniform_generator.sv =====
// draw: result on the ports with done after the DRAW and MULT states; a new draw can be accepted in MULT
// (table difference and carry in the DRAW state, scaling multiply in the MULT state)
// reseed: busy while the seed generator divides the seed and then makes one bit per cycle
// a draw before any seeding first runs that reseed with the default seed
// rst clears control, carry and seeded flag; table contents are not reset
// the receiver cannot stall: each result is shown for one cycle with done
module lagged_fibonacci_uniform_generator import lfug_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                req_type,
  input  logic [MAX_W-1:0]    max_value,
  input  logic                cfg_we,
  input  logic [SEED_W-1:0]   cfg_wdata,
  output logic                done,
  output logic [ENTRY_W-1:0]  uniform_fraction,
  output logic [MAX_W-1:0]    scaled_value
);

`include "lagged_fibonacci_uniform_generator_defines.svh"

  top_state_t state, state_next;

  logic [SEED_W-1:0] seed_word;
  logic [FRAC_W-1:0] carry;
  logic              seeded;
  logic              pend;
  logic [MAX_W-1:0]  max_q;
  entry_t            frac_q;

  logic accept;
  logic seed_start;

  fill_t             fill;
  logic [FRAC_W-1:0] seed_out;
  ring_ctrl_t        ring_ctrl;
  entry_t            tap_long, tap_short;

  logic [ENTRY_W:0]   diff_raw;
  entry_t             diff;
  logic [ENTRY_W-1:0] carry_sub;
  logic [FRAC_W-1:0]  carry_next;
  logic [ENTRY_W:0]   res_raw;
  entry_t             res;
  logic [ENTRY_W+MAX_W-1:0] prod;

  assign busy       = state == ST_SEED || state == ST_DRAW;
  assign accept     = start && !busy;
  assign seed_start = accept && (req_type == REQ_RESEED || !seeded);

  lfug_seeder u_seeder (
    .clk         (clk),
    .rst         (rst),
    .start       (seed_start),
    .use_default (req_type == REQ_DRAW),
    .seed_word   (seed_word),
    .fill        (fill),
    .word        (seed_out)
  );

  assign ring_ctrl.fwd  = state == ST_DRAW;
  assign ring_ctrl.back = fill.push;

  lfug_ring u_ring (
    .clk       (clk),
    .ctrl      (ring_ctrl),
    .fill_word ({1'b0, seed_out}),
    .head_word (diff),
    .tap_long  (tap_long),
    .tap_short (tap_short)
  );

  // subtractive lag step, entries kept in 1..2^24
  assign diff_raw = {1'b0, tap_long} - {1'b0, tap_short};
  assign diff = (diff_raw[ENTRY_W] || diff_raw == '0) ? diff_raw[ENTRY_W-1:0] + ONE_UNIT
                                                     : diff_raw[ENTRY_W-1:0];

  assign carry_sub  = {1'b0, carry} - CARRY_STEP;
  assign carry_next = carry_sub[FRAC_W] ? carry_sub[FRAC_W-1:0] + CARRY_MOD
                                        : carry_sub[FRAC_W-1:0];

  assign res_raw = {1'b0, diff} - {2'b0, carry_next};
  assign res = res_raw[ENTRY_W] ? res_raw[ENTRY_W-1:0] + ONE_UNIT : res_raw[ENTRY_W-1:0];

  assign prod = frac_q * max_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE, ST_MULT: begin
        if (accept) begin
          state_next = seed_start ? ST_SEED : ST_DRAW;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SEED: begin
        if (fill.last) begin
          state_next = pend ? ST_DRAW : ST_IDLE;
        end
      end
      ST_DRAW: state_next = ST_MULT;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_word <= '0;
      carry     <= CARRY_INIT;
      seeded    <= 1'b0;
      pend      <= 1'b0;
      done      <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed_word <= cfg_wdata;
      end
      if (accept) begin
        pend <= req_type == REQ_DRAW;
      end
      if (fill.last) begin
        carry  <= CARRY_INIT;
        seeded <= 1'b1;
      end else if (state == ST_DRAW) begin
        carry <= carry_next;
      end
      done <= state == ST_MULT;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      max_q <= max_value;
    end
    if (state == ST_DRAW) begin
      frac_q <= res;
    end
    if (state == ST_MULT) begin
      uniform_fraction <= frac_q;
      scaled_value     <= prod[FRAC_W+MAX_W-1:FRAC_W];
    end
  end

  `LFUG_ASSERT_NEXT(a_mult_gives_item, state == ST_MULT, done, "draw finished without item")
  `LFUG_ASSERT_NEXT(a_draw_to_mult, state == ST_DRAW, state == ST_MULT, "draw step not followed by scaling")
  `LFUG_ASSERT_NEXT(a_unseeded_draw_seeds, accept && req_type == REQ_DRAW && !seeded,
                    state == ST_SEED && pend, "unseeded draw did not seed first")
  `LFUG_ASSERT_NEXT(a_fill_end_state, fill.last, seeded && carry == CARRY_INIT,
                    "seeding end did not restore carry")
  `LFUG_ASSERT_NOW(a_fill_only_seeding, fill.push, state == ST_SEED, "table fill outside seeding")

endmodule
